FILE: rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  // Depth of the command queue between the parser and the byte emitter.
  localparam int unsigned FIFO_DEPTH = 4;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_WAIT   = 3'd0,
    MODE_STR    = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_HIGH   = 3'd4,
    MODE_HIGHBS = 3'd5,
    MODE_LOWHEX = 3'd6
  } mode_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_CTRL  = 3'd0,
    ERR_ESC   = 3'd1,
    ERR_HEX   = 3'd2,
    ERR_SURR  = 3'd3,
    ERR_END   = 3'd4,
    ERR_QUOTE = 3'd5
  } err_e;

  // One input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] err_code;
    logic       last;
  } out_item_t;

  // Single trailing result of a command: a plain byte, a close or an error.
  typedef struct packed {
    logic       vld;
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
  } tail_t;

  // Command from the parser: an optional code point to encode, then a tail.
  typedef struct packed {
    logic        head_vld;
    logic [20:0] head_cp;
    tail_t       tail;
  } cmd_t;

endpackage

FILE: rtl/jsu_chan_if.sv
// Valid/ready channel interface carrying one payload per request.
interface jsu_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/jsu_front.sv
// Parser front end: classifies each text byte and issues emit commands.
module jsu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jsu_pkg::in_item_t in_item_i,
  input  logic              full_i,
  output logic              push_o,
  output jsu_pkg::cmd_t     cmd_o
);

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [15:0] HighLo  = 16'hd800;
  localparam logic [15:0] HighHi  = 16'hdbff;
  localparam logic [15:0] LowLo   = 16'hdc00;
  localparam logic [15:0] LowHi   = 16'hdfff;
  localparam logic [20:0] SuppBase = 21'h10000;
  localparam logic [5:0]  SurrTag  = 6'b110110;

  jsu_pkg::mode_e mode_q, mode_d;
  logic [11:0]    acc_q, acc_d;
  logic [9:0]     hh_q, hh_d;
  logic [1:0]     dc_q, dc_d;

  logic           accept;
  logic [7:0]     b;
  logic           ended;
  logic [4:0]     hex;
  logic [15:0]    cp_full;
  logic           is_ws;
  logic [20:0]    lone_high_cp;
  jsu_pkg::cmd_t  cmd;

  // Hex digit decode; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Result of a byte seen inside the string body.
  function automatic jsu_pkg::tail_t str_tail(input logic [7:0] c);
    jsu_pkg::tail_t t;
    t = '{vld: 1'b0, kind: jsu_pkg::KIND_BYTE, data: 8'd0, err: jsu_pkg::ERR_CTRL};
    if (c == ChQuote) begin
      t.vld  = 1'b1;
      t.kind = jsu_pkg::KIND_CLOSE;
    end else if (c < ChSpace) begin
      t.vld  = 1'b1;
      t.kind = jsu_pkg::KIND_ERR;
      t.err  = jsu_pkg::ERR_CTRL;
    end else if (c != ChBslash) begin
      t.vld  = 1'b1;
      t.data = c;
    end
    return t;
  endfunction

  function automatic jsu_pkg::mode_e str_mode(input logic [7:0] c);
    jsu_pkg::mode_e m;
    if (c == ChQuote || c < ChSpace) begin
      m = jsu_pkg::MODE_WAIT;
    end else if (c == ChBslash) begin
      m = jsu_pkg::MODE_ESC;
    end else begin
      m = jsu_pkg::MODE_STR;
    end
    return m;
  endfunction

  // Result of the byte after a backslash; the 'u' case yields nothing here.
  function automatic jsu_pkg::tail_t esc_tail(input logic [7:0] c);
    jsu_pkg::tail_t t;
    t = '{vld: 1'b1, kind: jsu_pkg::KIND_BYTE, data: 8'd0, err: jsu_pkg::ERR_CTRL};
    case (c)
      ChQuote, ChBslash, ChSlash: t.data = c;
      8'h62: t.data = 8'h08;
      8'h66: t.data = 8'h0c;
      8'h6e: t.data = 8'h0a;
      8'h72: t.data = 8'h0d;
      8'h74: t.data = 8'h09;
      ChLowU: t.vld = 1'b0;
      default: begin
        t.kind = jsu_pkg::KIND_ERR;
        t.err  = jsu_pkg::ERR_ESC;
      end
    endcase
    return t;
  endfunction

  function automatic jsu_pkg::mode_e esc_mode(input logic [7:0] c);
    jsu_pkg::mode_e m;
    case (c)
      ChQuote, ChBslash, ChSlash, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74: m = jsu_pkg::MODE_STR;
      ChLowU:  m = jsu_pkg::MODE_HEX;
      default: m = jsu_pkg::MODE_WAIT;
    endcase
    return m;
  endfunction

  assign in_ready_o   = !full_i;
  assign accept       = in_valid_i && in_ready_o;
  assign b            = in_item_i.in_byte;
  assign ended        = in_item_i.text_end;
  assign hex          = hex_digit(b);
  assign cp_full      = {acc_q, hex[3:0]};
  assign is_ws        = (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  assign lone_high_cp = {5'd0, SurrTag, hh_q};

  // Next parser state.
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    hh_d   = hh_q;
    dc_d   = dc_q;
    if (ended) begin
      mode_d = jsu_pkg::MODE_WAIT;
      dc_d   = 2'd0;
    end else begin
      unique case (mode_q)
        jsu_pkg::MODE_WAIT: begin
          if (b == ChQuote) begin
            mode_d = jsu_pkg::MODE_STR;
          end
          dc_d = 2'd0;
        end
        jsu_pkg::MODE_STR: mode_d = str_mode(b);
        jsu_pkg::MODE_ESC: begin
          mode_d = esc_mode(b);
          dc_d   = 2'd0;
        end
        jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOWHEX: begin
          if (!hex[4]) begin
            mode_d = jsu_pkg::MODE_WAIT;
            dc_d   = 2'd0;
          end else if (dc_q == 2'd3) begin
            dc_d = 2'd0;
            if (mode_q == jsu_pkg::MODE_HEX) begin
              if (cp_full >= HighLo && cp_full <= HighHi) begin
                mode_d = jsu_pkg::MODE_HIGH;
                hh_d   = cp_full[9:0];
              end else begin
                mode_d = jsu_pkg::MODE_STR;
              end
            end else if (cp_full < LowLo || cp_full > LowHi) begin
              mode_d = jsu_pkg::MODE_WAIT;
            end else begin
              mode_d = jsu_pkg::MODE_STR;
            end
          end else begin
            acc_d = {acc_q[7:0], hex[3:0]};
            dc_d  = dc_q + 2'd1;
          end
        end
        jsu_pkg::MODE_HIGH: begin
          mode_d = (b == ChBslash) ? jsu_pkg::MODE_HIGHBS : str_mode(b);
        end
        jsu_pkg::MODE_HIGHBS: begin
          mode_d = (b == ChLowU) ? jsu_pkg::MODE_LOWHEX : esc_mode(b);
          dc_d   = 2'd0;
        end
        default: begin
          mode_d = jsu_pkg::MODE_WAIT;
          dc_d   = 2'd0;
        end
      endcase
    end
  end

  // Command for the emitter.
  always_comb begin
    cmd          = '0;
    cmd.tail     = '{vld: 1'b0, kind: jsu_pkg::KIND_BYTE, data: 8'd0,
                     err: jsu_pkg::ERR_CTRL};
    if (ended) begin
      cmd.tail.vld  = 1'b1;
      cmd.tail.kind = jsu_pkg::KIND_ERR;
      cmd.tail.err  = (mode_q == jsu_pkg::MODE_WAIT) ? jsu_pkg::ERR_QUOTE : jsu_pkg::ERR_END;
    end else begin
      unique case (mode_q)
        jsu_pkg::MODE_WAIT: begin
          if (b != ChQuote && !is_ws) begin
            cmd.tail.vld  = 1'b1;
            cmd.tail.kind = jsu_pkg::KIND_ERR;
            cmd.tail.err  = jsu_pkg::ERR_QUOTE;
          end
        end
        jsu_pkg::MODE_STR: cmd.tail = str_tail(b);
        jsu_pkg::MODE_ESC: cmd.tail = esc_tail(b);
        jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOWHEX: begin
          if (!hex[4]) begin
            cmd.tail.vld  = 1'b1;
            cmd.tail.kind = jsu_pkg::KIND_ERR;
            cmd.tail.err  = jsu_pkg::ERR_HEX;
          end else if (dc_q == 2'd3) begin
            if (mode_q == jsu_pkg::MODE_HEX) begin
              if (!(cp_full >= HighLo && cp_full <= HighHi)) begin
                cmd.head_vld = 1'b1;
                cmd.head_cp  = {5'd0, cp_full};
              end
            end else if (cp_full < LowLo || cp_full > LowHi) begin
              cmd.tail.vld  = 1'b1;
              cmd.tail.kind = jsu_pkg::KIND_ERR;
              cmd.tail.err  = jsu_pkg::ERR_SURR;
            end else begin
              // Combine the surrogate pair into one supplementary code point.
              cmd.head_vld = 1'b1;
              cmd.head_cp  = SuppBase + {1'b0, hh_q, cp_full[9:0]};
            end
          end
        end
        jsu_pkg::MODE_HIGH: begin
          if (b != ChBslash) begin
            cmd.head_vld = 1'b1;
            cmd.head_cp  = lone_high_cp;
            cmd.tail     = str_tail(b);
          end
        end
        jsu_pkg::MODE_HIGHBS: begin
          if (b != ChLowU) begin
            cmd.head_vld = 1'b1;
            cmd.head_cp  = lone_high_cp;
            cmd.tail     = esc_tail(b);
          end
        end
        default: begin
          cmd.tail.vld  = 1'b1;
          cmd.tail.kind = jsu_pkg::KIND_ERR;
          cmd.tail.err  = jsu_pkg::ERR_QUOTE;
        end
      endcase
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.head_vld || cmd.tail.vld);

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_WAIT;
      dc_q   <= 2'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      dc_q   <= dc_d;
    end
  end

  // Digit and surrogate holding registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= acc_d;
      hh_q  <= hh_d;
    end
  end

  a_high_held_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ended && mode_q == jsu_pkg::MODE_HEX && hex[4] && dc_q == 2'd3 &&
     mode_d == jsu_pkg::MODE_HIGH) |=> (hh_q == $past(cp_full[9:0])))
    else $error("held high surrogate not captured");

  a_digits_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == jsu_pkg::MODE_WAIT || mode_q == jsu_pkg::MODE_STR) |-> (dc_q == 2'd0))
    else $error("digit count left over outside hex modes");

endmodule

FILE: rtl/jsu_fifo.sv
// Short command queue between the parser and the emitter.
module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          vld_o,
  output jsu_pkg::cmd_t cmd_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  jsu_pkg::cmd_t entry_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_pop;

  assign full_o = (cnt_q == FullCnt);
  assign vld_o  = (cnt_q != '0);
  assign cmd_o  = entry_q[rd_q];
  assign do_pop = pop_i && vld_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count out of range");

endmodule

FILE: rtl/jsu_back.sv
// Emitter back end: expands each command into UTF-8 bytes and status results.
module jsu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_vld_i,
  input  jsu_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_item_t out_item_o
);

  localparam logic [20:0] Lim1 = 21'h80;
  localparam logic [20:0] Lim2 = 21'h800;
  localparam logic [20:0] Lim3 = 21'h10000;
  localparam logic [7:0]  Cont = 8'h80;
  localparam logic [7:0]  Lead2 = 8'hc0;
  localparam logic [7:0]  Lead3 = 8'he0;
  localparam logic [7:0]  Lead4 = 8'hf0;

  logic [1:0]         idx_q;
  logic               out_vld_q;
  jsu_pkg::out_item_t out_q;

  logic [2:0]         n_head;
  logic [2:0]         total;
  logic               in_head;
  logic               is_last;
  logic               load;
  logic [20:0]        cp;
  logic [7:0]         utf;
  jsu_pkg::out_item_t res;

  assign cp = cmd_i.head_cp;

  // Length of the UTF-8 sequence for the head code point.
  always_comb begin
    if (!cmd_i.head_vld) begin
      n_head = 3'd0;
    end else if (cp < Lim1) begin
      n_head = 3'd1;
    end else if (cp < Lim2) begin
      n_head = 3'd2;
    end else if (cp < Lim3) begin
      n_head = 3'd3;
    end else begin
      n_head = 3'd4;
    end
  end

  assign total   = n_head + {2'd0, cmd_i.tail.vld};
  assign in_head = {1'b0, idx_q} < n_head;
  assign is_last = ({1'b0, idx_q} == total - 3'd1);

  // Select the UTF-8 byte at the current position.
  always_comb begin
    utf = 8'd0;
    case (n_head)
      3'd1: utf = cp[7:0];
      3'd2: begin
        case (idx_q)
          2'd0:    utf = Lead2 | {3'd0, cp[10:6]};
          default: utf = Cont | {2'd0, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (idx_q)
          2'd0:    utf = Lead3 | {4'd0, cp[15:12]};
          2'd1:    utf = Cont | {2'd0, cp[11:6]};
          default: utf = Cont | {2'd0, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx_q)
          2'd0:    utf = Lead4 | {5'd0, cp[20:18]};
          2'd1:    utf = Cont | {2'd0, cp[17:12]};
          2'd2:    utf = Cont | {2'd0, cp[11:6]};
          default: utf = Cont | {2'd0, cp[5:0]};
        endcase
      end
      default: utf = 8'd0;
    endcase
  end

  // Result at the current position.
  always_comb begin
    res.last = is_last;
    if (in_head) begin
      res.out_kind = jsu_pkg::KIND_BYTE;
      res.out_byte = utf;
      res.err_code = 3'd0;
    end else begin
      res.out_kind = cmd_i.tail.kind;
      res.out_byte = (cmd_i.tail.kind == jsu_pkg::KIND_BYTE) ? cmd_i.tail.data : 8'd0;
      res.err_code = (cmd_i.tail.kind == jsu_pkg::KIND_ERR) ? cmd_i.tail.err : 3'd0;
    end
  end

  assign load        = cmd_vld_i && (!out_vld_q || out_ready_i);
  assign pop_o       = load && is_last;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Position within the head command and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  a_no_empty_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_vld_i |-> (total != 3'd0) && ({1'b0, idx_q} < total))
    else $error("queued command empty or position past its end");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.out_kind != jsu_pkg::KIND_BYTE) |-> out_q.last)
    else $error("close or error result not marked last");

endmodule

FILE: rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
// The block takes one text byte per cycle: the parser classifies it
// combinationally and, when the byte produces results, places one command in a
// queue of FifoDepth entries. The emitter turns each command into one to four
// results and delivers one result per cycle, while the output is ready, through
// a registered output. The input stalls only while the command queue is full,
// which happens when the output is held back or when many multi-byte results
// arrive close together. An accepted byte's first result passes through the
// command queue and the output register. Errors and the closing quote are
// reported as the last result of their byte, and the parser then waits for a
// new opening quote.
module json_string_unescape_utf8 #(
  parameter int unsigned FifoDepth = jsu_pkg::FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsu_chan_if.sink   in_i,
  jsu_chan_if.source out_o
);

  logic          full;
  logic          push;
  logic          pop;
  logic          cmd_vld;
  jsu_pkg::cmd_t cmd_in;
  jsu_pkg::cmd_t cmd_out;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_i.data),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (cmd_vld),
    .cmd_o  (cmd_out)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_vld_i   (cmd_vld),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.data)
  );

endmodule

FILE: verif/tb.sv
// Testbench for the JSON string unescaper: random JSON strings in, checked UTF-8 results out.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned StringBytes = 280;
  localparam int unsigned CalmTail    = 50;
  localparam int unsigned HoldAt      = 100;
  localparam int unsigned HoldCycles  = 40;
  localparam int unsigned DrainCycles = 16;

  // Predicts the decoded bytes, closes and errors, and checks what the block delivers.
  class unescape_scoreboard;
    jsu_pkg::mode_e     mode;
    logic [15:0]        accum;
    logic [15:0]        high_held;
    logic [1:0]         digits;
    jsu_pkg::out_item_t step_q[$];
    jsu_pkg::out_item_t pending_utf8[$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
      clear();
      mismatches = 0;
      checked = 0;
    endfunction

    static function int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void clear();
      mode = jsu_pkg::MODE_WAIT;
      accum = '0;
      high_held = '0;
      digits = '0;
    endfunction

    function void push_result(jsu_pkg::kind_e k, logic [7:0] val, logic [2:0] code);
      jsu_pkg::out_item_t r;
      r = '0;
      r.out_kind = k;
      r.out_byte = val;
      r.err_code = code;
      step_q.insert(step_q.size(), r);
    endfunction

    function void push_char(logic [7:0] val);
      push_result(jsu_pkg::KIND_BYTE, val, '0);
    endfunction

    // An error ends the string and sends the parser back to the opening quote.
    function void abort(jsu_pkg::err_e code);
      push_result(jsu_pkg::KIND_ERR, '0, code);
      clear();
    endfunction

    function void emit_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
        push_char(cp[7:0]);
      end else if (cp < 21'h800) begin
        push_char(8'hc0 | cp[10:6]);
        push_char(8'h80 | cp[5:0]);
      end else if (cp < 21'h10000) begin
        push_char(8'he0 | cp[15:12]);
        push_char(8'h80 | cp[11:6]);
        push_char(8'h80 | cp[5:0]);
      end else begin
        push_char(8'hf0 | cp[20:18]);
        push_char(8'h80 | cp[17:12]);
        push_char(8'h80 | cp[11:6]);
        push_char(8'h80 | cp[5:0]);
      end
    endfunction

    function void string_char(logic [7:0] c);
      if (c == "\"") begin
        push_result(jsu_pkg::KIND_CLOSE, '0, '0);
        clear();
      end else if (c < 8'h20) begin
        abort(jsu_pkg::ERR_CTRL);
      end else if (c == "\\") begin
        mode = jsu_pkg::MODE_ESC;
      end else begin
        push_char(c);
        mode = jsu_pkg::MODE_STR;
      end
    endfunction

    function void escape_char(logic [7:0] c);
      logic [7:0] ch;
      mode = jsu_pkg::MODE_STR;
      case (c)
        "\"", "\\", "/": ch = c;
        "b": ch = 8'h08;
        "f": ch = 8'h0c;
        "n": ch = 8'h0a;
        "r": ch = 8'h0d;
        "t": ch = 8'h09;
        "u": begin
          accum = '0;
          digits = '0;
          mode = jsu_pkg::MODE_HEX;
          return;
        end
        default: begin
          abort(jsu_pkg::ERR_ESC);
          return;
        end
      endcase
      push_char(ch);
    endfunction

    // Works out the results of one accepted request and queues them.
    function void note_request(jsu_pkg::in_item_t req);
      logic [7:0]  c;
      logic [20:0] cp;
      int          d;
      step_q.delete();
      c = req.in_byte;
      if (req.text_end) begin
        abort(mode == jsu_pkg::MODE_WAIT ? jsu_pkg::ERR_QUOTE : jsu_pkg::ERR_END);
      end else begin
        case (mode)
          jsu_pkg::MODE_STR: string_char(c);
          jsu_pkg::MODE_ESC: escape_char(c);
          jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOWHEX: begin
            d = nibble_of(c);
            if (d < 0) begin
              abort(jsu_pkg::ERR_HEX);
            end else begin
              accum = {accum[11:0], d[3:0]};
              if (digits != 2'd3) begin
                digits = digits + 2'd1;
              end else begin
                digits = '0;
                if (mode == jsu_pkg::MODE_HEX) begin
                  // A high surrogate waits for a possible low half.
                  if (accum >= 16'hd800 && accum <= 16'hdbff) begin
                    high_held = accum;
                    mode = jsu_pkg::MODE_HIGH;
                  end else begin
                    emit_utf8({5'd0, accum});
                    mode = jsu_pkg::MODE_STR;
                  end
                end else if (accum < 16'hdc00 || accum > 16'hdfff) begin
                  abort(jsu_pkg::ERR_SURR);
                end else begin
                  cp = 21'h10000 + (21'(high_held - 16'hd800) << 10)
                       + 21'(accum - 16'hdc00);
                  emit_utf8(cp);
                  high_held = '0;
                  mode = jsu_pkg::MODE_STR;
                end
              end
            end
          end
          jsu_pkg::MODE_HIGH: begin
            if (c == "\\") begin
              mode = jsu_pkg::MODE_HIGHBS;
            end else begin
              emit_utf8({5'd0, high_held});
              high_held = '0;
              string_char(c);
            end
          end
          jsu_pkg::MODE_HIGHBS: begin
            if (c == "u") begin
              accum = '0;
              digits = '0;
              mode = jsu_pkg::MODE_LOWHEX;
            end else begin
              emit_utf8({5'd0, high_held});
              high_held = '0;
              escape_char(c);
            end
          end
          default: begin
            if (c == "\"") begin
              clear();
              mode = jsu_pkg::MODE_STR;
            end else if (!(c inside {8'h20, 8'h09, 8'h0d, 8'h0a})) begin
              abort(jsu_pkg::ERR_QUOTE);
            end
          end
        endcase
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      pending_utf8 = {pending_utf8, step_q};
    endfunction

    task report(string msg);
      $display("[%0t] result %0d: %s", $time, checked, msg);
      mismatches++;
    endtask

    // Compares one delivered result with the oldest prediction.
    task check_result(jsu_pkg::out_item_t got);
      jsu_pkg::out_item_t want;
      checked++;
      if (pending_utf8.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h code %0d",
                         got.out_kind, got.out_byte, got.err_code));
        return;
      end
      want = pending_utf8.pop_front();
      if (got.out_kind !== want.out_kind)
        report($sformatf("kind %0d, want %0d", got.out_kind, want.out_kind));
      if (got.out_byte !== want.out_byte)
        report($sformatf("byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.err_code !== want.err_code)
        report($sformatf("error code %0d, want %0d", got.err_code, want.err_code));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_chan_if #(.payload_t(jsu_pkg::in_item_t))  in_if ();
  jsu_chan_if #(.payload_t(jsu_pkg::out_item_t)) out_if ();

  json_string_unescape_utf8 i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  unescape_scoreboard sb;
  jsu_pkg::in_item_t  text_q[$];
  int unsigned        accepted_cnt = 0;
  int unsigned        cycle_cnt = 0;
  bit                 quiet = 1'b0;
  bit                 held_off = 1'b0;

  logic [7:0] esc_letters [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
  logic [7:0] ws_chars [4] = '{8'h20, 8'h09, 8'h0d, 8'h0a};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stimulus building blocks.
  function automatic void add_byte(logic [7:0] c);
    jsu_pkg::in_item_t req;
    req.in_byte = c;
    req.text_end = 1'b0;
    text_q.insert(text_q.size(), req);
  endfunction

  function automatic void add_end();
    jsu_pkg::in_item_t req;
    req.in_byte = 8'($urandom_range(0, 255));
    req.text_end = 1'b1;
    text_q.insert(text_q.size(), req);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
  endfunction

  function automatic void add_u(logic [15:0] v);
    add_byte("\\");
    add_byte("u");
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[4 * i +: 4]));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'hff)); while (c == "\"" || c == "\\");
    return c;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (unescape_scoreboard::nibble_of(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] bad_escape();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
    return c;
  endfunction

  function automatic logic [15:0] any_code();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 16'h7f));
      1: return 16'($urandom_range(16'h80, 16'h7ff));
      2: return 16'($urandom_range(16'h800, 16'hd7ff));
      default: return 16'($urandom_range(16'he000, 16'hffff));
    endcase
  endfunction

  function automatic logic [15:0] high_half();
    return 16'($urandom_range(16'hd800, 16'hdbff));
  endfunction

  function automatic logic [15:0] low_half();
    return 16'($urandom_range(16'hdc00, 16'hdfff));
  endfunction

  function automatic void add_piece();
    case ($urandom_range(0, 9))
      0, 1, 2: add_byte(plain_char());
      3: begin
        add_byte("\\");
        add_byte(esc_letters[3'($urandom_range(0, 7))]);
      end
      4, 5: add_u(any_code());
      6: begin
        add_u(high_half());
        add_u(low_half());
      end
      7: add_u(low_half());
      // High surrogate without a partner: a plain byte or another escape follows.
      8: begin
        add_u(high_half());
        add_byte(plain_char());
      end
      default: begin
        add_u(high_half());
        add_byte("\\");
        add_byte(esc_letters[3'($urandom_range(0, 7))]);
      end
    endcase
  endfunction

  // One JSON string; every third one breaks off with one of the error cases in turn.
  function automatic void add_string(int unsigned idx);
    logic [15:0] v;
    repeat ($urandom_range(0, 2)) add_byte(ws_chars[2'($urandom_range(0, 3))]);
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)));
      else add_end();
    end
    add_byte("\"");
    repeat ($urandom_range(1, 4)) add_piece();
    if (idx % 3 != 0) begin
      add_byte("\"");
    end else begin
      case ((idx / 3) % 6)
        0: add_byte(8'($urandom_range(0, 8'h1f)));
        1: begin
          add_byte("\\");
          add_byte(bad_escape());
        end
        2: begin
          add_byte("\\");
          add_byte("u");
          repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15))));
          add_byte(non_hex());
        end
        3: begin
          add_u(high_half());
          do v = 16'($urandom_range(0, 16'hffff)); while (v >= 16'hdc00 && v <= 16'hdfff);
          add_u(v);
        end
        4: begin
          add_u(high_half());
          add_byte("\\");
          add_byte("u");
          repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15))));
          add_byte(non_hex());
        end
        default: begin
          // Cut the text off in the middle of different constructs.
          case ($urandom_range(0, 3))
            0: add_byte("\\");
            1: begin
              add_byte("\\");
              add_byte("u");
              add_byte(hex_char(4'($urandom_range(0, 15))));
            end
            2: add_u(high_half());
            default: ;
          endcase
          add_end();
        end
      endcase
    end
  endfunction

  function automatic void build_stimulus();
    int unsigned idx;
    // Directed opening: stray bytes, end while waiting, extremes and each error but a bad low surrogate.
    add_byte(8'h20);
    add_byte("x");
    add_end();
    add_byte("\"");
    add_byte(8'hff);
    add_byte("\\");
    add_byte("n");
    add_u(16'hd800);
    add_byte("A");
    add_byte(8'h1f);
    add_byte("\"");
    add_byte("\\");
    add_byte("q");
    add_byte("\"");
    add_byte("\\");
    add_byte("u");
    add_byte("g");
    add_byte("\"");
    add_end();
    idx = 1;
    while (text_q.size() < StringBytes) begin
      add_string(idx);
      idx++;
    end
  endfunction

  task automatic send_request(jsu_pkg::in_item_t req);
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(req);
    accepted_cnt++;
  endtask

  // Sender and end of run.
  initial begin
    sb = new();
    in_if.valid = 1'b0;
    in_if.data = '0;
    rst_ni = 1'b0;
    build_stimulus();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (text_q[i]) begin
      quiet = (i + CalmTail >= text_q.size());
      if (!quiet && $urandom_range(0, 5) == 0) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end
      send_request(text_q[i]);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending_utf8.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, and one long hold-off that fills the block.
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held_off && accepted_cnt >= HoldAt) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
